@@ rtl/iee_pkg.sv @@
// Shared types, codes and helper functions of the infix expression evaluator.
package iee_pkg;

    // Input beat: one character and its end mark.
    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_expression;
    } item_t;

    // Result beat: evaluated value and status code.
    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         status;
    } result_t;

    // Status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DIV0      = 3'd1;
    localparam logic [2:0] ST_MALFORMED = 3'd2;
    localparam logic [2:0] ST_STACK     = 3'd3;
    localparam logic [2:0] ST_LITERAL   = 3'd4;

    // Operator stack codes.
    localparam logic [2:0] OP_OPEN = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    // Characters of the grammar.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_DIV   = 8'h2F;

    // Largest literal that fits a signed 32-bit value.
    localparam logic [35:0] LIT_MAX = 36'd2147483647;

    // Datapath command codes.
    localparam logic [3:0] C_NONE      = 4'd0;
    localparam logic [3:0] C_DIGIT     = 4'd1;
    localparam logic [3:0] C_CLOSE_LIT = 4'd2;
    localparam logic [3:0] C_PUSH_OPEN = 4'd3;
    localparam logic [3:0] C_ERR_MALF  = 4'd4;
    localparam logic [3:0] C_PUSH_BIN  = 4'd5;
    localparam logic [3:0] C_POP_OPEN  = 4'd6;
    localparam logic [3:0] C_RD_OP     = 4'd7;
    localparam logic [3:0] C_RD_B      = 4'd8;
    localparam logic [3:0] C_LD_B      = 4'd9;
    localparam logic [3:0] C_LD_A      = 4'd10;
    localparam logic [3:0] C_EXEC      = 4'd11;
    localparam logic [3:0] C_WRITE     = 4'd12;
    localparam logic [3:0] C_RD_BOTTOM = 4'd13;
    localparam logic [3:0] C_FINISH    = 4'd14;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic [3:0] code;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic err_nz;
        logic is_digit;
        logic is_open;
        logic is_close;
        logic is_bin;
        logic in_lit;
        logic after;
        logic last;
        logic otop_zero;
        logic top_open;
        logic top_lower;
        logic vtop_lt2;
        logic vtop_one;
        logic op_div;
        logic b_zero;
        logic div_done;
        logic out_free;
    } dp_stat_t;

    // Maps a character to its operator code; other characters give OP_OPEN.
    function automatic logic [2:0] sym_op(input logic [7:0] c);
        logic [2:0] op;
        case (c)
            CH_ADD:  op = OP_ADD;
            CH_SUB:  op = OP_SUB;
            CH_MUL:  op = OP_MUL;
            CH_DIV:  op = OP_DIV;
            default: op = OP_OPEN;
        endcase
        return op;
    endfunction

    // High binding for * and /.
    function automatic logic op_high(input logic [2:0] op);
        return (op == OP_MUL) || (op == OP_DIV);
    endfunction

endpackage

@@ rtl/iee_div.sv @@
// Signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
module iee_div import iee_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [32:0] rem_sh;
    logic [32:0] diff;

    // One restoring step on the magnitudes.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        rem_sh    = {rem_reg, quo_reg[31]};
        diff      = rem_sh - {1'b0, dvs_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            rem_next  = 32'd0;
            quo_next  = dividend[31] ? (32'd0 - dividend) : dividend;
            dvs_next  = divisor[31] ? (32'd0 - divisor) : divisor;
            neg_next  = dividend[31] ^ divisor[31];
        end
        else if (busy_reg)
        begin
            if (!diff[32])
            begin
                rem_next = diff[31:0];
            end
            else
            begin
                rem_next = rem_sh[31:0];
            end
            quo_next = {quo_reg[30:0], ~diff[32]};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;

endmodule

@@ rtl/iee_dp.sv @@
// Datapath: stacks, literal builder, arithmetic and result register.
module iee_dp import iee_pkg::*;
#(
    parameter int VALUE_STACK_DEPTH    = 16,
    parameter int OPERATOR_STACK_DEPTH = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     capture,
    input  item_t    item,
    input  cmd_t     cmd,
    input  logic     result_ready,
    output dp_stat_t stat,
    output logic     result_valid,
    output result_t  result
);

    localparam int VAW = (VALUE_STACK_DEPTH > 1) ? $clog2(VALUE_STACK_DEPTH) : 1;
    localparam int VCW = $clog2(VALUE_STACK_DEPTH + 1);
    localparam int OAW = (OPERATOR_STACK_DEPTH > 1) ? $clog2(OPERATOR_STACK_DEPTH) : 1;
    localparam int OCW = $clog2(OPERATOR_STACK_DEPTH + 1);
    localparam logic [VCW-1:0] VFULL = VCW'(VALUE_STACK_DEPTH);
    localparam logic [OCW-1:0] OFULL = OCW'(OPERATOR_STACK_DEPTH);

    logic [31:0] vmem [VALUE_STACK_DEPTH];
    logic [2:0]  omem [OPERATOR_STACK_DEPTH];

    logic [VCW-1:0] vtop_reg, vtop_next;
    logic [OCW-1:0] otop_reg, otop_next;
    logic [31:0]    acc_reg, acc_next;
    logic           in_lit_reg, in_lit_next;
    logic           after_reg, after_next;
    logic [2:0]     err_reg, err_next;
    logic [7:0]     sym_reg;
    logic           last_reg;
    logic [31:0]    vrd_reg;
    logic [2:0]     ord_reg;
    logic [31:0]    a_reg, b_reg, r_reg;
    logic           res_valid_reg, res_valid_next;
    result_t        res_reg;

    logic [VCW-1:0] vm1, vm2;
    logic [OCW-1:0] om1;
    logic [35:0]    lit_n;
    logic [2:0]     new_op;
    logic           is_digit;
    logic           v_we;
    logic [VAW-1:0] v_waddr;
    logic [31:0]    v_wdata;
    logic           v_re;
    logic [VAW-1:0] v_raddr;
    logic           o_we;
    logic [OAW-1:0] o_waddr;
    logic [2:0]     o_wdata;
    logic           div_start;
    logic           div_done;
    logic [31:0]    div_q;

    // Keeps the first error.
    function automatic logic [2:0] raise(input logic [2:0] cur, input logic [2:0] code);
        return (cur == ST_OK) ? code : cur;
    endfunction

    assign vm1      = vtop_reg - VCW'(1);
    assign vm2      = vtop_reg - VCW'(2);
    assign om1      = otop_reg - OCW'(1);
    assign is_digit = (sym_reg >= CH_ZERO) && (sym_reg <= CH_NINE);
    assign new_op   = sym_op(sym_reg);
    assign lit_n    = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                    + {32'd0, sym_reg[3:0] - CH_ZERO[3:0]};

    // Next state of the stack pointers, literal and flags per command.
    always_comb
    begin
        vtop_next      = vtop_reg;
        otop_next      = otop_reg;
        acc_next       = acc_reg;
        in_lit_next    = in_lit_reg;
        after_next     = after_reg;
        err_next       = err_reg;
        res_valid_next = res_valid_reg && !result_ready;
        v_we           = 1'b0;
        v_waddr        = vtop_reg[VAW-1:0];
        v_wdata        = acc_reg;
        v_re           = 1'b0;
        v_raddr        = vm1[VAW-1:0];
        o_we           = 1'b0;
        o_waddr        = otop_reg[OAW-1:0];
        o_wdata        = OP_OPEN;
        div_start      = 1'b0;
        case (cmd.code)
            C_DIGIT:
            begin
                if (!in_lit_reg && after_reg)
                begin
                    err_next = raise(err_reg, ST_MALFORMED);
                end
                else if (lit_n > LIT_MAX)
                begin
                    err_next = raise(err_reg, ST_LITERAL);
                end
                else
                begin
                    acc_next    = lit_n[31:0];
                    in_lit_next = 1'b1;
                    after_next  = 1'b1;
                end
            end
            C_CLOSE_LIT:
            begin
                in_lit_next = 1'b0;
                acc_next    = 32'd0;
                if (vtop_reg == VFULL)
                begin
                    err_next = raise(err_reg, ST_STACK);
                end
                else
                begin
                    v_we      = 1'b1;
                    vtop_next = vtop_reg + VCW'(1);
                end
            end
            C_PUSH_OPEN, C_PUSH_BIN:
            begin
                o_wdata = (cmd.code == C_PUSH_BIN) ? new_op : OP_OPEN;
                if (cmd.code == C_PUSH_BIN)
                begin
                    after_next = 1'b0;
                end
                if (otop_reg == OFULL)
                begin
                    err_next = raise(err_reg, ST_STACK);
                end
                else
                begin
                    o_we      = 1'b1;
                    otop_next = otop_reg + OCW'(1);
                end
            end
            C_ERR_MALF:
            begin
                err_next = raise(err_reg, ST_MALFORMED);
            end
            C_POP_OPEN:
            begin
                otop_next = om1;
            end
            C_RD_B:
            begin
                v_re = 1'b1;
            end
            C_LD_B:
            begin
                v_re    = 1'b1;
                v_raddr = vm2[VAW-1:0];
            end
            C_EXEC:
            begin
                if ((ord_reg == OP_DIV) && (b_reg == 32'd0))
                begin
                    err_next = raise(err_reg, ST_DIV0);
                end
                else if (ord_reg == OP_DIV)
                begin
                    div_start = 1'b1;
                end
                else if (!((ord_reg == OP_ADD) || (ord_reg == OP_SUB) || (ord_reg == OP_MUL)))
                begin
                    err_next = raise(err_reg, ST_MALFORMED);
                end
            end
            C_WRITE:
            begin
                v_we      = 1'b1;
                v_waddr   = vm2[VAW-1:0];
                v_wdata   = (ord_reg == OP_DIV) ? div_q : r_reg;
                vtop_next = vm1;
                otop_next = om1;
            end
            C_RD_BOTTOM:
            begin
                v_re    = 1'b1;
                v_raddr = '0;
            end
            C_FINISH:
            begin
                res_valid_next = 1'b1;
                vtop_next      = '0;
                otop_next      = '0;
                acc_next       = 32'd0;
                in_lit_next    = 1'b0;
                after_next     = 1'b0;
                err_next       = ST_OK;
            end
            default:
            begin
            end
        endcase
    end

    // Control and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtop_reg      <= '0;
            otop_reg      <= '0;
            acc_reg       <= 32'd0;
            in_lit_reg    <= 1'b0;
            after_reg     <= 1'b0;
            err_reg       <= ST_OK;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            vtop_reg      <= vtop_next;
            otop_reg      <= otop_next;
            acc_reg       <= acc_next;
            in_lit_reg    <= in_lit_next;
            after_reg     <= after_next;
            err_reg       <= err_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Value stack memory, one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            vmem[v_waddr] <= v_wdata;
        end
        if (v_re)
        begin
            vrd_reg <= vmem[v_raddr];
        end
    end

    // Operator stack memory, read at the top entry.
    always_ff @(posedge clk)
    begin
        if (o_we)
        begin
            omem[o_waddr] <= o_wdata;
        end
        if (cmd.code == C_RD_OP)
        begin
            ord_reg <= omem[om1[OAW-1:0]];
        end
    end

    // Captured beat, operands, ALU result and result beat.
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            sym_reg  <= item.symbol;
            last_reg <= item.end_of_expression;
        end
        if (cmd.code == C_LD_B)
        begin
            b_reg <= vrd_reg;
        end
        if (cmd.code == C_LD_A)
        begin
            a_reg <= vrd_reg;
        end
        if (cmd.code == C_EXEC)
        begin
            case (ord_reg)
                OP_ADD:  r_reg <= a_reg + b_reg;
                OP_SUB:  r_reg <= a_reg - b_reg;
                default: r_reg <= a_reg * b_reg;
            endcase
        end
        if (cmd.code == C_FINISH)
        begin
            res_reg.status <= err_reg;
            res_reg.value  <= (err_reg == ST_OK) ? vrd_reg : 32'd0;
        end
    end

    iee_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (a_reg),
        .divisor  (b_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Status toward the controller.
    always_comb
    begin
        stat.err_nz    = (err_reg != ST_OK);
        stat.is_digit  = is_digit;
        stat.is_open   = (sym_reg == CH_OPEN);
        stat.is_close  = (sym_reg == CH_CLOSE);
        stat.is_bin    = (new_op != OP_OPEN);
        stat.in_lit    = in_lit_reg;
        stat.after     = after_reg;
        stat.last      = last_reg;
        stat.otop_zero = (otop_reg == '0);
        stat.top_open  = (ord_reg == OP_OPEN);
        stat.top_lower = !op_high(ord_reg) && op_high(new_op);
        stat.vtop_lt2  = (vtop_reg < VCW'(2));
        stat.vtop_one  = (vtop_reg == VCW'(1));
        stat.op_div    = (ord_reg == OP_DIV);
        stat.b_zero    = (b_reg == 32'd0);
        stat.div_done  = div_done;
        stat.out_free  = !res_valid_reg || result_ready;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

@@ rtl/iee_ctrl.sv @@
// Controller state machine that sequences tokens and reductions.
module iee_ctrl import iee_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  dp_stat_t stat,
    output cmd_t     cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_TOK    = 4'd2;
    localparam logic [3:0] S_OPRD   = 4'd3;
    localparam logic [3:0] S_OPCHK  = 4'd4;
    localparam logic [3:0] S_R0     = 4'd5;
    localparam logic [3:0] S_R1     = 4'd6;
    localparam logic [3:0] S_R2     = 4'd7;
    localparam logic [3:0] S_R3     = 4'd8;
    localparam logic [3:0] S_DIVW   = 4'd9;
    localparam logic [3:0] S_WR     = 4'd10;
    localparam logic [3:0] S_ENDC   = 4'd11;
    localparam logic [3:0] S_FIN0   = 4'd12;
    localparam logic [3:0] S_RESCHK = 4'd13;
    localparam logic [3:0] S_OUT    = 4'd14;

    localparam logic [1:0] M_CLOSE = 2'd0;
    localparam logic [1:0] M_BIN   = 2'd1;
    localparam logic [1:0] M_FIN   = 2'd2;

    logic [3:0] state_reg, state_next;
    logic [1:0] mode_reg, mode_next;

    // Next state and command.
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cmd.code   = C_NONE;
        item_ready = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = stat.err_nz ? S_ENDC : S_DISP;
                end
            end
            S_DISP:
            begin
                if (stat.is_digit)
                begin
                    cmd.code   = C_DIGIT;
                    state_next = S_ENDC;
                end
                else
                begin
                    if (stat.in_lit)
                    begin
                        cmd.code = C_CLOSE_LIT;
                    end
                    state_next = S_TOK;
                end
            end
            S_TOK:
            begin
                state_next = S_ENDC;
                if (stat.err_nz)
                begin
                    state_next = S_ENDC;
                end
                else if (stat.is_open)
                begin
                    cmd.code = stat.after ? C_ERR_MALF : C_PUSH_OPEN;
                end
                else if (stat.is_close || stat.is_bin)
                begin
                    if (!stat.after)
                    begin
                        cmd.code = C_ERR_MALF;
                    end
                    else
                    begin
                        mode_next  = stat.is_close ? M_CLOSE : M_BIN;
                        state_next = S_OPRD;
                    end
                end
            end
            S_OPRD:
            begin
                if (!stat.otop_zero)
                begin
                    cmd.code   = C_RD_OP;
                    state_next = S_OPCHK;
                end
                else
                begin
                    case (mode_reg)
                        M_CLOSE:
                        begin
                            cmd.code   = C_ERR_MALF;
                            state_next = S_ENDC;
                        end
                        M_BIN:
                        begin
                            cmd.code   = C_PUSH_BIN;
                            state_next = S_ENDC;
                        end
                        default:
                        begin
                            cmd.code   = C_RD_BOTTOM;
                            state_next = S_RESCHK;
                        end
                    endcase
                end
            end
            S_OPCHK:
            begin
                state_next = S_R0;
                case (mode_reg)
                    M_CLOSE:
                    begin
                        if (stat.top_open)
                        begin
                            cmd.code   = C_POP_OPEN;
                            state_next = S_ENDC;
                        end
                    end
                    M_BIN:
                    begin
                        if (stat.top_open || stat.top_lower)
                        begin
                            cmd.code   = C_PUSH_BIN;
                            state_next = S_ENDC;
                        end
                    end
                    default:
                    begin
                        if (stat.top_open)
                        begin
                            cmd.code   = C_ERR_MALF;
                            state_next = S_ENDC;
                        end
                    end
                endcase
            end
            S_R0:
            begin
                if (stat.vtop_lt2)
                begin
                    cmd.code   = C_ERR_MALF;
                    state_next = S_ENDC;
                end
                else
                begin
                    cmd.code   = C_RD_B;
                    state_next = S_R1;
                end
            end
            S_R1:
            begin
                cmd.code   = C_LD_B;
                state_next = S_R2;
            end
            S_R2:
            begin
                cmd.code   = C_LD_A;
                state_next = S_R3;
            end
            S_R3:
            begin
                cmd.code = C_EXEC;
                if (stat.op_div)
                begin
                    state_next = stat.b_zero ? S_ENDC : S_DIVW;
                end
                else
                begin
                    state_next = S_WR;
                end
            end
            S_DIVW:
            begin
                if (stat.div_done)
                begin
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                cmd.code   = C_WRITE;
                state_next = stat.err_nz ? S_ENDC : S_OPRD;
            end
            S_ENDC:
            begin
                if (!stat.last)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.err_nz)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    if (stat.in_lit)
                    begin
                        cmd.code = C_CLOSE_LIT;
                    end
                    state_next = S_FIN0;
                end
            end
            S_FIN0:
            begin
                if (stat.err_nz)
                begin
                    state_next = S_OUT;
                end
                else if (!stat.after)
                begin
                    cmd.code   = C_ERR_MALF;
                    state_next = S_OUT;
                end
                else
                begin
                    mode_next  = M_FIN;
                    state_next = S_OPRD;
                end
            end
            S_RESCHK:
            begin
                if (!stat.vtop_one)
                begin
                    cmd.code = C_ERR_MALF;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.code   = C_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= M_CLOSE;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

endmodule

@@ rtl/infix_expression_evaluator_core.sv @@
// Per character, from accept to ready again: a digit, '(' or an ignored character is handled
// directly; an operator or ')' also runs each reduction it triggers, and a division
// reduction waits on the bit-serial divider.
// The end mark also runs its final reductions, and waits while a result stalls.
// One character in work at a time; the result register lets the next beat in.
// Reset (rst_n, asynchronous) empties both stacks, clears the literal and error.
module infix_expression_evaluator_core import iee_pkg::*;
#(
    parameter int VALUE_STACK_DEPTH    = 16,
    parameter int OPERATOR_STACK_DEPTH = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    dp_stat_t stat;
    cmd_t     cmd;

    iee_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    iee_dp #(
        .VALUE_STACK_DEPTH    (VALUE_STACK_DEPTH),
        .OPERATOR_STACK_DEPTH (OPERATOR_STACK_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .capture      (item_valid && item_ready),
        .item         (item),
        .cmd          (cmd),
        .result_ready (result_ready),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

    // A failed expression never reports a value.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != ST_OK) |-> (result.value == 32'sd0))
        else $error("nonzero value with error status");

    // Status stays within its defined codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.status <= ST_LITERAL))
        else $error("undefined status code");

    // Each accepted beat is worked on before another is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("beat accepted while busy");

    // A new result is loaded only when the output register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.code == C_FINISH) |-> (!result_valid || result_ready))
        else $error("result overwritten");

endmodule
